// ===== design/window_max_dominant_colorize_defines.svh =====
// Assertion macros shared by the window_max_dominant_colorize RTL.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef WINDOW_MAX_DOMINANT_COLORIZE_DEFINES_SVH
`define WINDOW_MAX_DOMINANT_COLORIZE_DEFINES_SVH

// same-cycle implication
`define WMDC_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define WMDC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/wmdc_pkg.sv =====
// Package for window_max_dominant_colorize: widths, reset values, codes and types.
// No dependencies.
package wmdc_pkg;

	localparam int MAX_COLS_DEFAULT = 4096;
	localparam int CH_W             = 8;
	localparam int ROW_W            = 16;
	localparam int COL_W            = 12;
	localparam int WIDTH_W          = 13;
	localparam int ALPHA_W          = 9;
	localparam int CFG_DATA_W       = 16;
	localparam int CFG_IDX_W        = 2;

	localparam int MIN_DIM          = 3;
	localparam int ALPHA_ONE        = 256;
	localparam int SAT_MAX          = 255;

	localparam int RST_IMAGE_WIDTH  = 640;
	localparam int RST_IMAGE_HEIGHT = 480;
	localparam int RST_ALPHA        = 0;

	localparam int RES_FIFO_DEPTH   = 8;
	localparam int RES_FIFO_AW      = 3;
	localparam int RES_FIFO_CW      = 4;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_IMAGE_WIDTH  = 2'd0;
	localparam cfg_idx_t CFG_IMAGE_HEIGHT = 2'd1;
	localparam cfg_idx_t CFG_ALPHA_Q8     = 2'd2;

	typedef struct packed {
		logic [CH_W-1:0] pixel_b;
		logic [CH_W-1:0] pixel_g;
		logic [CH_W-1:0] pixel_r;
		logic [CH_W-1:0] pixel_a;
	} pixel_t;

	typedef struct packed {
		logic [ROW_W-1:0] out_row;
		logic [COL_W-1:0] out_col;
		logic [CH_W-1:0]  out_b;
		logic [CH_W-1:0]  out_g;
		logic [CH_W-1:0]  out_r;
		logic [CH_W-1:0]  out_a;
	} result_t;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
	} coord_t;

	typedef enum logic [1:0] {
		DOM_R = 2'b00,
		DOM_G = 2'b01,
		DOM_B = 2'b10
	} dom_t;

	typedef struct packed {
		logic   valid;
		dom_t   dom;
		coord_t coord;
		pixel_t center;
	} boost_req_t;

endpackage

// ===== design/wmdc_line_ram.sv =====
// One line buffer: single write port, single read port with registered read data.
// Depends on wmdc_pkg.
module wmdc_line_ram #(
	parameter int DEPTH = wmdc_pkg::MAX_COLS_DEFAULT,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic            clk,
	input  logic            rd_en,
	input  logic [AW-1:0]   rd_addr,
	output wmdc_pkg::pixel_t rd_data,
	input  logic            wr_en,
	input  logic [AW-1:0]   wr_addr,
	input  wmdc_pkg::pixel_t wr_data
);
	import wmdc_pkg::*;

	pixel_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== design/wmdc_window.sv =====
// 3x3 window registers, per-channel neighborhood maximum and dominant-channel pick.
// Depends on wmdc_pkg.
module wmdc_window (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 shift,
	input  logic                 emit,
	input  wmdc_pkg::coord_t     coord,
	input  wmdc_pkg::pixel_t     col_up,
	input  wmdc_pkg::pixel_t     col_mid,
	input  wmdc_pkg::pixel_t     col_px,
	output logic                 valid_s2,
	output wmdc_pkg::boost_req_t req_s3
);
	import wmdc_pkg::*;

	pixel_t          win_q [3][3];
	coord_t          coord_s2;
	logic [CH_W-1:0] mb, mg, mr;
	dom_t            dom;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					win_q[r][c] <= '0;
				end
			end
		end else if (shift) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
			end
			win_q[0][2] <= col_up;
			win_q[1][2] <= col_mid;
			win_q[2][2] <= col_px;
		end
	end

	always_comb begin
		mb = '0;
		mg = '0;
		mr = '0;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				if (win_q[r][c].pixel_b > mb) mb = win_q[r][c].pixel_b;
				if (win_q[r][c].pixel_g > mg) mg = win_q[r][c].pixel_g;
				if (win_q[r][c].pixel_r > mr) mr = win_q[r][c].pixel_r;
			end
		end
		// ties: R, then G, then B
		if (mr >= mg && mr >= mb) begin
			dom = DOM_R;
		end else if (mg >= mb) begin
			dom = DOM_G;
		end else begin
			dom = DOM_B;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			req_s3   <= '0;
		end else begin
			valid_s2     <= shift && emit;
			req_s3.valid <= valid_s2;
			if (valid_s2) begin
				req_s3.dom    <= dom;
				req_s3.coord  <= coord_s2;
				req_s3.center <= win_q[1][1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			coord_s2 <= coord;
		end
	end

endmodule

// ===== design/wmdc_boost.sv =====
// Scales the center pixel: dominant channel by 1+alpha, others by 1-alpha, saturated.
// Depends on wmdc_pkg.
module wmdc_boost (
	input  wmdc_pkg::boost_req_t req,
	input  logic [wmdc_pkg::ALPHA_W-1:0] alpha,
	output logic                 push,
	output wmdc_pkg::result_t    res
);
	import wmdc_pkg::*;

	localparam int PHI_W  = ALPHA_W + 1;
	localparam int PROD_W = CH_W + PHI_W;

	logic [PHI_W-1:0] plus, minus, phi_b, phi_g, phi_r;

	function automatic logic [CH_W-1:0] scale_sat(input logic [CH_W-1:0] v,
		input logic [PHI_W-1:0] phi);
		logic [PROD_W-1:0]        prod;
		logic [PROD_W-CH_W-1:0]   q;
		prod = PROD_W'(v) * PROD_W'(phi);
		q = prod[PROD_W-1:CH_W];
		return (q > (PROD_W-CH_W)'(SAT_MAX)) ? CH_W'(SAT_MAX) : q[CH_W-1:0];
	endfunction

	always_comb begin
		plus  = PHI_W'(ALPHA_ONE) + PHI_W'(alpha);
		minus = PHI_W'(ALPHA_ONE) - PHI_W'(alpha);
		phi_b = minus;
		phi_g = minus;
		phi_r = minus;
		case (req.dom)
			DOM_R:   phi_r = plus;
			DOM_G:   phi_g = plus;
			DOM_B:   phi_b = plus;
			default: phi_r = plus;
		endcase
		push        = req.valid;
		res.out_row = req.coord.row;
		res.out_col = req.coord.col;
		res.out_b   = scale_sat(req.center.pixel_b, phi_b);
		res.out_g   = scale_sat(req.center.pixel_g, phi_g);
		res.out_r   = scale_sat(req.center.pixel_r, phi_r);
		res.out_a   = req.center.pixel_a;
	end

endmodule

// ===== design/wmdc_result_fifo.sv =====
// Result queue between the boost stage and the output channel.
// Depends on wmdc_pkg and window_max_dominant_colorize_defines.svh.
`include "window_max_dominant_colorize_defines.svh"
module wmdc_result_fifo (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	input  wmdc_pkg::result_t                 push_data,
	input  logic                              pop,
	output logic                              valid,
	output wmdc_pkg::result_t                 data,
	output logic [wmdc_pkg::RES_FIFO_CW-1:0]  count
);
	import wmdc_pkg::*;

	result_t                mem_q [RES_FIFO_DEPTH];
	logic [RES_FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [RES_FIFO_CW-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + RES_FIFO_AW'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + RES_FIFO_AW'(1);
			if (push && !pop) begin
				count_q <= count_q + RES_FIFO_CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - RES_FIFO_CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	assign valid = (count_q != '0);
	assign data  = mem_q[rd_ptr_q];
	assign count = count_q;

	`WMDC_ASSERT_IMPL(a_fifo_no_overflow, push, (count_q < RES_FIFO_CW'(RES_FIFO_DEPTH)) || pop, "result fifo overflow")
	`WMDC_ASSERT_NEXT(a_fifo_count_up, push && !pop, count_q == RES_FIFO_CW'($past(count_q) + 1'b1), "result fifo count did not advance")

endmodule

// ===== design/window_max_dominant_colorize.sv =====
// Streaming 3x3 dominant-color boost on BGRA pixels in raster order. One pixel item is taken
// per clock; a result passes the s1, s2 and s3 registers and then waits in an eight-entry
// result queue. pixel_stall rises only when eight results are in flight or queued, so the
// block keeps one item per clock as long as results are taken. Two line buffers hold the
// previous rows (registered read at accept, write in the cycle after); no clearing pass after reset.
// Depends on wmdc_pkg, window_max_dominant_colorize_defines.svh and the wmdc_* modules.
`include "window_max_dominant_colorize_defines.svh"
module window_max_dominant_colorize #(
	parameter int MAX_COLS = wmdc_pkg::MAX_COLS_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                pixel_valid,
	output logic                                pixel_stall,
	input  wmdc_pkg::pixel_t                    pixel,
	output logic                                result_valid,
	input  logic                                result_stall,
	output wmdc_pkg::result_t                   result,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  wmdc_pkg::cfg_idx_t                  cfg_index,
	input  logic [wmdc_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import wmdc_pkg::*;

	localparam int CW = $clog2(MAX_COLS);
	localparam int WW = (CW + 1 > WIDTH_W) ? CW + 1 : WIDTH_W;
	localparam int XW = (CW > COL_W) ? CW : COL_W;

	logic [WIDTH_W-1:0] image_width_q;
	logic [ROW_W-1:0]   image_height_q;
	logic [ALPHA_W-1:0] alpha_q;
	logic [CW-1:0]      col_q;
	logic [ROW_W-1:0]   row_q;

	logic [WW-1:0]      w_ext, w_sel;
	logic [CW:0]        w_eff, w_m1, col_inc;
	logic [CW-1:0]      col_eff, col_next;
	logic               col_wrap;
	logic [ROW_W-1:0]   h_eff, row_eff, row_next;
	logic [ROW_W:0]     row_inc;
	logic [XW-1:0]      col_m1;
	logic [ALPHA_W-1:0] alpha_eff;
	logic               emit, pix_accept;
	coord_t             coord;

	logic               v_s1, emit_s1;
	pixel_t             px_s1;
	coord_t             coord_s1;
	logic [CW-1:0]      col_s1;

	pixel_t             up_rd, mid_rd;
	logic               v_s2;
	boost_req_t         req_s3;
	logic               push;
	result_t            push_data;
	logic [RES_FIFO_CW-1:0] fifo_cnt, pending;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= WIDTH_W'(RST_IMAGE_WIDTH);
			image_height_q <= ROW_W'(RST_IMAGE_HEIGHT);
			alpha_q        <= ALPHA_W'(RST_ALPHA);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data[WIDTH_W-1:0];
				CFG_IMAGE_HEIGHT: image_height_q <= cfg_data[ROW_W-1:0];
				CFG_ALPHA_Q8:     alpha_q        <= cfg_data[ALPHA_W-1:0];
				default: ;
			endcase
		end
	end

	// position and geometry clamping
	always_comb begin
		w_ext = WW'(image_width_q);
		if (w_ext < WW'(MIN_DIM)) begin
			w_sel = WW'(MIN_DIM);
		end else if (w_ext > WW'(MAX_COLS)) begin
			w_sel = WW'(MAX_COLS);
		end else begin
			w_sel = w_ext;
		end
		w_eff   = w_sel[CW:0];
		w_m1    = w_eff - (CW + 1)'(1);
		col_eff = ({1'b0, col_q} >= w_eff) ? w_m1[CW-1:0] : col_q;
		col_inc = {1'b0, col_eff} + (CW + 1)'(1);
		col_wrap = (col_inc >= w_eff);
		col_next = col_wrap ? '0 : col_inc[CW-1:0];

		h_eff   = (image_height_q < ROW_W'(MIN_DIM)) ? ROW_W'(MIN_DIM) : image_height_q;
		row_eff = (row_q >= h_eff) ? h_eff - ROW_W'(1) : row_q;
		row_inc = {1'b0, row_eff} + (ROW_W + 1)'(1);
		if (col_wrap) begin
			row_next = (row_inc >= {1'b0, h_eff}) ? '0 : row_inc[ROW_W-1:0];
		end else begin
			row_next = row_eff;
		end

		emit      = (row_eff >= ROW_W'(2)) && ({1'b0, col_eff} >= (CW + 1)'(2));
		col_m1    = XW'(col_eff) - XW'(1);
		coord.row = row_eff - ROW_W'(1);
		coord.col = col_m1[COL_W-1:0];
		alpha_eff = (alpha_q > ALPHA_W'(ALPHA_ONE)) ? ALPHA_W'(ALPHA_ONE) : alpha_q;
	end

	assign pix_accept = pixel_valid && !pixel_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			v_s1    <= 1'b0;
			emit_s1 <= 1'b0;
		end else begin
			v_s1    <= pix_accept;
			emit_s1 <= pix_accept && emit;
			if (pix_accept) begin
				col_q <= col_next;
				row_q <= row_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pix_accept) begin
			px_s1    <= pixel;
			coord_s1 <= coord;
			col_s1   <= col_eff;
		end
	end

	// line buffers: read at accept, rotate in the cycle after
	wmdc_line_ram #(.DEPTH(MAX_COLS)) u_line_upper (
		.clk     (clk),
		.rd_en   (pix_accept),
		.rd_addr (col_eff),
		.rd_data (up_rd),
		.wr_en   (v_s1),
		.wr_addr (col_s1),
		.wr_data (mid_rd)
	);

	wmdc_line_ram #(.DEPTH(MAX_COLS)) u_line_middle (
		.clk     (clk),
		.rd_en   (pix_accept),
		.rd_addr (col_eff),
		.rd_data (mid_rd),
		.wr_en   (v_s1),
		.wr_addr (col_s1),
		.wr_data (px_s1)
	);

	wmdc_window u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.shift    (v_s1),
		.emit     (emit_s1),
		.coord    (coord_s1),
		.col_up   (up_rd),
		.col_mid  (mid_rd),
		.col_px   (px_s1),
		.valid_s2 (v_s2),
		.req_s3   (req_s3)
	);

	wmdc_boost u_boost (
		.req   (req_s3),
		.alpha (alpha_eff),
		.push  (push),
		.res   (push_data)
	);

	wmdc_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (result_valid && !result_stall),
		.valid     (result_valid),
		.data      (result),
		.count     (fifo_cnt)
	);

	// results in flight plus queued must fit the queue
	assign pending = fifo_cnt + RES_FIFO_CW'(emit_s1) + RES_FIFO_CW'(v_s2)
		+ RES_FIFO_CW'(req_s3.valid);
	assign pixel_stall = (pending >= RES_FIFO_CW'(RES_FIFO_DEPTH));

	`WMDC_ASSERT_IMPL(a_credit_bound, 1'b1, pending <= RES_FIFO_CW'(RES_FIFO_DEPTH), "more results in flight than queue space")
	`WMDC_ASSERT_IMPL(a_result_latency, pix_accept && emit, ##3 req_s3.valid, "interior pixel did not reach the boost stage")
	`WMDC_ASSERT_NEXT(a_col_in_range, pix_accept, {1'b0, col_q} < $past(w_eff), "column counter past row width")

endmodule
